FILE: rtl/loop_device_talker_listener_unit_defines.svh
// Assertion macros for the loop device talker/listener unit
`ifndef LOOP_DEVICE_TALKER_LISTENER_UNIT_DEFINES_SVH
`define LOOP_DEVICE_TALKER_LISTENER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LDTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LDTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LDTL_ASSERT(lbl, prop, msg)
`define LDTL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/ldtl_pkg.sv
// Types, constants and helpers shared by the loop device talker/listener unit
package ldtl_pkg;

	localparam int ID_LEN = 16;
	localparam int LDTL_QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_CMD   = 2'd1;
	localparam logic [1:0] OP_READY = 2'd2;

	localparam logic [1:0] REG_ID_LOW       = 2'd0;
	localparam logic [1:0] REG_ID_HIGH      = 2'd1;
	localparam logic [1:0] REG_ACCESSORY_ID = 2'd2;
	localparam logic [1:0] REG_DEFAULT_ADDR = 2'd3;

	localparam logic [7:0] ACCESSORY_ID_RESET = 8'd65;
	localparam logic [4:0] DEFAULT_ADDR_RESET = 5'd4;

	localparam logic [3:0] ROLE_IDLE   = 4'h0;
	localparam logic [3:0] ROLE_LISTEN = 4'h8;
	localparam logic [3:0] ROLE_TALK   = 4'h4;
	localparam logic [3:0] ROLE_DATA   = 4'h2;
	localparam logic [3:0] ROLE_ONE    = 4'h1;

	localparam logic [10:0] EOT_FRAME = 11'h540;

	localparam logic [2:0] GRP_UNIVERSAL = 3'd0;
	localparam logic [2:0] GRP_LISTEN    = 3'd1;
	localparam logic [2:0] GRP_TALK      = 3'd2;
	localparam logic [2:0] GRP_UNCONFIG  = 3'd4;

	localparam logic [7:0] CMD_SDC = 8'd4;
	localparam logic [7:0] CMD_DCL = 8'd20;
	localparam logic [4:0] ADDR_UNLISTEN = 5'd31;
	localparam logic [4:0] SUB_IFC = 5'd16;
	localparam logic [4:0] SUB_AAU = 5'd26;

	localparam logic [7:0] RDY_NRD = 8'd66;
	localparam logic [7:0] RDY_SDA = 8'd96;
	localparam logic [7:0] RDY_SST = 8'd97;
	localparam logic [7:0] RDY_SDI = 8'd98;
	localparam logic [7:0] RDY_SAI = 8'd99;
	localparam logic [7:0] RDY_AAD_END = 8'h9E;

	typedef enum logic [2:0] {
		KIND_PASS,
		KIND_DATA,
		KIND_CMD,
		KIND_READY,
		KIND_AUTO_ADDR
	} kind_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [10:0] frame_in;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic [7:0]  serial_status;
	} in_item_t;

	typedef struct packed {
		logic [10:0] frame_out;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        rx_take;
		logic        buffer_clear;
	} out_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [10:0] frame;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic [7:0]  serial_status;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	function automatic logic [7:0] id_char(input logic [127:0] id, input logic [4:0] i);
		if (i >= 5'(ID_LEN))
			return 8'd0;
		return id[{i[3:0], 3'b000} +: 8];
	endfunction

endpackage

FILE: rtl/ldtl_front.sv
// Front end: accept loop frames, classify them and queue them for the back end
module ldtl_front import ldtl_pkg::*; #(
	parameter int DEPTH = LDTL_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output q_head_t  head,
	input  logic     pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	q_entry_t             entry;
	logic                 push;
	logic [7:0]           n;

	always_comb begin
		n = in_data.frame_in[7:0];
		entry.frame         = in_data.frame_in;
		entry.rx_valid      = in_data.rx_valid;
		entry.rx_byte       = in_data.rx_byte;
		entry.serial_status = in_data.serial_status;
		unique case (in_data.opcode)
			OP_DATA:  entry.kind = KIND_DATA;
			OP_CMD:   entry.kind = KIND_CMD;
			OP_READY: begin
				if (!n[7])
					entry.kind = KIND_READY;
				else if (n < RDY_AAD_END)
					entry.kind = KIND_AUTO_ADDR;
				else
					entry.kind = KIND_PASS;
			end
			default:  entry.kind = KIND_PASS;
		endcase
	end

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign push = in_valid && !in_stall;
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/ldtl_back.sv
// Back end: role and address state, frame handling and the output register
module ldtl_back import ldtl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_head_t     head,
	output logic        pop,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [63:0] id_low_q;
	logic [63:0] id_high_q;
	logic [7:0]  accessory_q;
	logic [4:0]  default_addr_q;
	logic [3:0]  role_q;
	logic [7:0]  addr_q;
	logic [4:0]  id_ptr_q;
	logic        out_valid_q;
	out_item_t   out_q;

	q_entry_t    e;
	logic [7:0]  n;
	logic [4:0]  low5;
	logic [7:0]  c;
	logic [3:0]  role_n;
	logic [7:0]  addr_n;
	logic [4:0]  ptr_n;
	out_item_t   res;

	assign pop = head.valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		e      = head.entry;
		n      = e.frame[7:0];
		low5   = n[4:0];
		c      = id_char({id_high_q, id_low_q}, id_ptr_q);
		role_n = role_q;
		addr_n = addr_q;
		ptr_n  = id_ptr_q;
		res.frame_out    = e.frame;
		res.tx_valid     = 1'b0;
		res.tx_byte      = 8'd0;
		res.rx_take      = 1'b0;
		res.buffer_clear = 1'b0;
		unique case (e.kind)
			KIND_DATA: begin
				if (role_q[3]) begin
					if (role_q[2]) begin
						if (role_q[1] && role_q[0]) begin
							if (id_ptr_q != '0) begin
								res.frame_out = 11'(c);
								ptr_n = (c == 8'd0) ? '0 : id_ptr_q + 5'd1;
							end
							if (ptr_n == '0) begin
								res.frame_out = EOT_FRAME;
								role_n = ROLE_TALK;
							end
						end else if (role_q[1]) begin
							if (e.rx_valid) begin
								res.frame_out = 11'(e.rx_byte);
								res.rx_take = 1'b1;
							end else begin
								res.frame_out = EOT_FRAME;
								role_n = ROLE_TALK;
							end
						end else begin
							res.frame_out = EOT_FRAME;
							role_n = ROLE_TALK;
						end
					end else begin
						res.tx_valid = 1'b1;
						res.tx_byte = n;
					end
				end
			end
			KIND_CMD: begin
				unique case (n[7:5])
					GRP_UNIVERSAL: begin
						if ((n == CMD_SDC && role_q[3]) || n == CMD_DCL)
							res.buffer_clear = 1'b1;
					end
					GRP_LISTEN: begin
						if (low5 == ADDR_UNLISTEN) begin
							if (!role_q[2])
								role_n = ROLE_IDLE;
						end else if (low5 == addr_q[4:0]) begin
							role_n = ROLE_LISTEN;
						end
					end
					GRP_TALK: begin
						if (low5 == addr_q[4:0])
							role_n = ROLE_TALK;
						else if (role_q[2])
							role_n = ROLE_IDLE;
					end
					GRP_UNCONFIG: begin
						if (low5 == SUB_IFC)
							role_n = ROLE_IDLE;
						else if (low5 == SUB_AAU)
							addr_n = 8'(default_addr_q);
					end
					default: ;
				endcase
			end
			KIND_READY: begin
				if (role_q[2]) begin
					unique case (n)
						RDY_NRD: role_n = role_q & ~ROLE_DATA;
						RDY_SDA: begin
							if (e.rx_valid) begin
								res.frame_out = 11'(e.rx_byte);
								res.rx_take = 1'b1;
								role_n = ROLE_LISTEN | ROLE_TALK | ROLE_DATA;
							end else begin
								res.frame_out = EOT_FRAME;
							end
						end
						RDY_SST: begin
							res.frame_out = 11'(e.serial_status);
							role_n = ROLE_LISTEN | ROLE_TALK | ROLE_ONE;
						end
						RDY_SDI: begin
							res.frame_out = 11'(id_char({id_high_q, id_low_q}, 5'd0));
							ptr_n = 5'd1;
							role_n = ROLE_LISTEN | ROLE_TALK | ROLE_DATA | ROLE_ONE;
						end
						RDY_SAI: begin
							res.frame_out = 11'(accessory_q);
							role_n = ROLE_LISTEN | ROLE_TALK | ROLE_ONE;
						end
						default: ;
					endcase
				end
			end
			KIND_AUTO_ADDR: begin
				if (!addr_q[7]) begin
					addr_n = n;
					res.frame_out = e.frame + 11'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_low_q       <= '0;
			id_high_q      <= '0;
			accessory_q    <= ACCESSORY_ID_RESET;
			default_addr_q <= DEFAULT_ADDR_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ID_LOW:       id_low_q <= cfg_data;
				REG_ID_HIGH:      id_high_q <= cfg_data;
				REG_ACCESSORY_ID: accessory_q <= cfg_data[7:0];
				REG_DEFAULT_ADDR: default_addr_q <= cfg_data[4:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q      <= ROLE_IDLE;
			addr_q      <= '0;
			id_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			role_q      <= role_n;
			addr_q      <= addr_n;
			id_ptr_q    <= ptr_n;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= res;
	end

endmodule

FILE: rtl/loop_device_talker_listener_unit.sv
// Top level of the loop device talker/listener unit
//
// Input channel: in_valid/in_stall carry one received loop frame per transfer,
// tagged as data, command or ready, with the receive byte offer and the serial
// status that go with it. Output channel: out_valid/out_stall carry the frame
// to retransmit together with the transmitter byte, the receive-byte take and
// the buffer clear pulse. Configuration: cfg_valid/cfg_ready with cfg_index
// and cfg_data write the ID string, accessory ID and default address; cfg_ready
// is always high and writes belong to idle periods.
// A transfer is accepted into a short queue; when nothing stalls the back end
// takes one entry per cycle, so throughput is one frame per cycle, and
// out_valid rises once the frame has passed the queue and the output register.
// The rate is set by the single state update in the back end. When out_stall
// is high while out_valid is high, the output register holds; the queue keeps
// accepting until it is full, then in_stall rises.
// Reset leaves the device idle, unaddressed, with an empty ID string,
// accessory ID 65 and default address 4.
`include "loop_device_talker_listener_unit_defines.svh"

module loop_device_talker_listener_unit import ldtl_pkg::*; #(
	parameter int QUEUE_DEPTH = LDTL_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	q_head_t q_head;
	logic    q_pop;

	assign cfg_ready = 1'b1;

	ldtl_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.head     (q_head),
		.pop      (q_pop)
	);

	ldtl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`LDTL_ASSERT(a_tx_byte_matches,
		out_valid && out_data.tx_valid |-> out_data.frame_out[7:0] == out_data.tx_byte,
		"transmit byte differs from passed frame")
	`LDTL_ASSERT(a_tx_rx_exclusive,
		out_valid |-> !(out_data.tx_valid && out_data.rx_take),
		"transmit and receive take in one result")
	`LDTL_ASSERT_NEXT(a_push_lands,
		in_valid && !in_stall && !q_head.valid, q_head.valid,
		"accepted transfer missing from queue")

endmodule

FILE: tb/sv/tb_loop_device_talker_listener_unit.sv
// Testbench for the loop device talker/listener unit: directed and random frames checked against a predictor
`timescale 1ns / 100ps

module tb_loop_device_talker_listener_unit;
	import ldtl_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [7:0] AAD_FIRST = 8'h80;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_FRAMES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_ID_LOW;
	logic [63:0] cfg_data = '0;

	logic [3:0] role_q = ROLE_IDLE;
	logic [7:0] addr_q = '0;
	logic [4:0] idptr_q = '0;
	logic [63:0] id_lo_q = '0;
	logic [63:0] id_hi_q = '0;
	logic [7:0] acc_q = ACCESSORY_ID_RESET;
	logic [4:0] def_q = DEFAULT_ADDR_RESET;

	out_item_t pending_frames[$];
	int unsigned mismatch_count = 0;
	int unsigned frames_sent = 0;
	int unsigned burst_left = 1;
	int unsigned cycles = 0;
	int unsigned stall_mode = 0;

	loop_device_talker_listener_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cycles % 64 == 0)
			stall_mode <= $urandom_range(0, 4);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			3: out_stall <= cycles[0];
			default: out_stall <= (cycles[4:3] == 2'b11);
		endcase
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("unexpected transfer", out_data.frame_out, 0);
			end else begin
				want = pending_frames.pop_front();
				if (out_data.frame_out !== want.frame_out)
					report_mismatch("frame_out", out_data.frame_out, want.frame_out);
				if (out_data.tx_valid !== want.tx_valid)
					report_mismatch("tx_valid", out_data.tx_valid, want.tx_valid);
				if (out_data.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", out_data.tx_byte, want.tx_byte);
				if (out_data.rx_take !== want.rx_take)
					report_mismatch("rx_take", out_data.rx_take, want.rx_take);
				if (out_data.buffer_clear !== want.buffer_clear)
					report_mismatch("buffer_clear", out_data.buffer_clear, want.buffer_clear);
			end
		end
	end

	function automatic logic [7:0] id_byte(logic [4:0] i);
		if (i >= ID_LEN)
			return 8'h00;
		if (i < 8)
			return id_lo_q[8*i +: 8];
		return id_hi_q[8*(i-8) +: 8];
	endfunction

	task automatic predict_loop_frame(input in_item_t it, output out_item_t res);
		logic [10:0] fr;
		logic [7:0] msg;
		logic [7:0] c;
		logic [4:0] low5;
		logic [4:0] my;
		res = '0;
		fr = it.frame_in;
		msg = fr[7:0];
		low5 = msg[4:0];
		my = addr_q[4:0];
		case (it.opcode)
			OP_DATA: begin
				if ((role_q & ROLE_LISTEN) != 0) begin
					if ((role_q & ROLE_TALK) != 0) begin
						if ((role_q & ROLE_DATA) != 0 && (role_q & ROLE_ONE) != 0) begin
							if (idptr_q != 0) begin
								c = id_byte(idptr_q);
								fr = {3'b000, c};
								idptr_q = (c == 0) ? 5'd0 : idptr_q + 5'd1;
							end
							if (idptr_q == 0) begin
								fr = EOT_FRAME;
								role_q = ROLE_TALK;
							end
						end else if ((role_q & ROLE_DATA) != 0) begin
							if (it.rx_valid) begin
								fr = {3'b000, it.rx_byte};
								res.rx_take = 1'b1;
							end else begin
								fr = EOT_FRAME;
								role_q = ROLE_TALK;
							end
						end else begin
							fr = EOT_FRAME;
							role_q = ROLE_TALK;
						end
					end else begin
						res.tx_valid = 1'b1;
						res.tx_byte = msg;
					end
				end
			end
			OP_CMD: begin
				case (msg[7:5])
					GRP_UNIVERSAL: begin
						if ((msg == CMD_SDC && (role_q & ROLE_LISTEN) != 0) || msg == CMD_DCL)
							res.buffer_clear = 1'b1;
					end
					GRP_LISTEN: begin
						if (low5 == ADDR_UNLISTEN) begin
							if ((role_q & ROLE_TALK) == 0)
								role_q = ROLE_IDLE;
						end else if (low5 == my) begin
							role_q = ROLE_LISTEN;
						end
					end
					GRP_TALK: begin
						if (low5 == my)
							role_q = ROLE_TALK;
						else if ((role_q & ROLE_TALK) != 0)
							role_q = ROLE_IDLE;
					end
					GRP_UNCONFIG: begin
						if (low5 == SUB_IFC)
							role_q = ROLE_IDLE;
						else if (low5 == SUB_AAU)
							addr_q = {3'b000, def_q};
					end
					default: ;
				endcase
			end
			OP_READY: begin
				if (msg < AAD_FIRST) begin
					if ((role_q & ROLE_TALK) != 0) begin
						case (msg)
							RDY_NRD: role_q = role_q & ~ROLE_DATA;
							RDY_SDA: begin
								if (it.rx_valid) begin
									fr = {3'b000, it.rx_byte};
									res.rx_take = 1'b1;
									role_q = ROLE_LISTEN | ROLE_TALK | ROLE_DATA;
								end else begin
									fr = EOT_FRAME;
								end
							end
							RDY_SST: begin
								fr = {3'b000, it.serial_status};
								role_q = ROLE_LISTEN | ROLE_TALK | ROLE_ONE;
							end
							RDY_SDI: begin
								fr = {3'b000, id_byte(5'd0)};
								idptr_q = 5'd1;
								role_q = ROLE_LISTEN | ROLE_TALK | ROLE_DATA | ROLE_ONE;
							end
							RDY_SAI: begin
								fr = {3'b000, acc_q};
								role_q = ROLE_LISTEN | ROLE_TALK | ROLE_ONE;
							end
							default: ;
						endcase
					end
				end else if (msg < RDY_AAD_END) begin
					if (addr_q[7] == 1'b0) begin
						addr_q = msg;
						fr = fr + 11'd1;
					end
				end
			end
			default: ;
		endcase
		res.frame_out = fr;
	endtask

	function automatic in_item_t make_frame(logic [1:0] op, logic [7:0] msg, bit rxv);
		in_item_t it;
		it.opcode = op;
		it.frame_in = {3'($urandom_range(0, 7)), msg};
		it.rx_valid = rxv;
		it.rx_byte = 8'($urandom);
		it.serial_status = 8'($urandom);
		return it;
	endfunction

	task automatic send_frame(input in_item_t it);
		out_item_t res;
		int unsigned gap;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		predict_loop_frame(it, res);
		pending_frames.push_back(res);
		frames_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_msg(logic [1:0] op, logic [7:0] msg, bit rxv);
		send_frame(make_frame(op, msg, rxv));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(logic [63:0] lo, logic [63:0] hi, logic [7:0] acc,
			logic [4:0] dflt);
		logic [63:0] vals[4];
		logic [1:0] regs[4];
		vals = '{lo, hi, {56'd0, acc}, {59'd0, dflt}};
		regs = '{REG_ID_LOW, REG_ID_HIGH, REG_ACCESSORY_ID, REG_DEFAULT_ADDR};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			case (regs[k])
				REG_ID_LOW: id_lo_q = vals[k];
				REG_ID_HIGH: id_hi_q = vals[k];
				REG_ACCESSORY_ID: acc_q = vals[k][7:0];
				default: def_q = vals[k][4:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_passthrough();
		send_frame('{OP_DATA, 11'h000, 1'b0, 8'h00, 8'h00});
		send_frame('{OP_SPARE, 11'h7FF, 1'b1, 8'hFF, 8'hFF});
		send_frame('{OP_CMD, 11'h7FF, 1'b1, 8'hFF, 8'hFF});
		send_msg(OP_READY, RDY_AAD_END, 1'b1);
	endtask

	task automatic test_auto_address();
		send_msg(OP_READY, RDY_AAD_END - 8'd1, 1'b0);
		send_msg(OP_READY, AAD_FIRST, 1'b0);
		send_msg(OP_CMD, {GRP_UNCONFIG, SUB_AAU}, 1'b0);
	endtask

	task automatic test_listener();
		send_msg(OP_CMD, {GRP_LISTEN, addr_q[4:0]}, 1'b0);
		send_frame('{OP_DATA, 11'h7FF, 1'b0, 8'h00, 8'h00});
		send_msg(OP_CMD, CMD_SDC, 1'b0);
		send_msg(OP_CMD, CMD_DCL, 1'b0);
		send_msg(OP_CMD, {GRP_LISTEN, ADDR_UNLISTEN}, 1'b0);
	endtask

	task automatic test_talker();
		send_msg(OP_CMD, {GRP_TALK, addr_q[4:0]}, 1'b0);
		send_msg(OP_READY, RDY_SDA, 1'b1);
		send_msg(OP_DATA, 8'h55, 1'b1);
		send_msg(OP_DATA, 8'h55, 1'b0);
		send_msg(OP_READY, RDY_SST, 1'b0);
		send_msg(OP_DATA, 8'hAA, 1'b1);
		send_msg(OP_READY, RDY_SAI, 1'b0);
		send_msg(OP_READY, RDY_NRD, 1'b0);
		send_msg(OP_READY, RDY_SDA, 1'b0);
	endtask

	task automatic test_send_id();
		wait_idle();
		apply_settings(64'h4241, 64'h0, ACCESSORY_ID_RESET, DEFAULT_ADDR_RESET);
		send_msg(OP_READY, RDY_SDI, 1'b0);
		repeat (3) send_msg(OP_DATA, 8'($urandom), 1'b1);
		send_msg(OP_CMD, {GRP_UNCONFIG, SUB_IFC}, 1'b0);
	endtask

	task automatic send_random_sequence();
		logic [4:0] my;
		my = addr_q[4:0];
		case ($urandom_range(0, 9))
			0, 1: begin
				send_msg(OP_CMD, {GRP_LISTEN, my}, 1'b0);
				repeat ($urandom_range(1, 8))
					send_msg(OP_DATA, 8'($urandom), $urandom_range(0, 1));
				if ($urandom_range(0, 2) == 0)
					send_msg(OP_CMD, $urandom_range(0, 1) ? CMD_SDC : CMD_DCL, 1'b0);
				if ($urandom_range(0, 1))
					send_msg(OP_CMD, {GRP_LISTEN, ADDR_UNLISTEN}, 1'b0);
			end
			2, 3: begin
				send_msg(OP_CMD, {GRP_TALK, my}, 1'b0);
				send_msg(OP_READY, RDY_SDA, $urandom_range(0, 7) != 0);
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 9) == 0)
						send_msg(OP_READY, RDY_NRD, 1'b1);
					send_msg(OP_DATA, 8'($urandom), $urandom_range(0, 5) != 0);
				end
			end
			4: begin
				send_msg(OP_CMD, {GRP_TALK, my}, 1'b0);
				send_msg(OP_READY, RDY_SDI, 1'b0);
				repeat ($urandom_range(1, 18))
					send_msg(OP_DATA, 8'($urandom), $urandom_range(0, 1));
			end
			5: begin
				send_msg(OP_CMD, {GRP_TALK, my}, 1'b0);
				send_msg(OP_READY, $urandom_range(0, 1) ? RDY_SST : RDY_SAI, 1'b0);
				repeat ($urandom_range(1, 2))
					send_msg(OP_DATA, 8'($urandom), $urandom_range(0, 1));
			end
			6: begin
				case ($urandom_range(0, 2))
					0: send_msg(OP_CMD, {GRP_UNCONFIG, SUB_AAU}, 1'b0);
					1: send_msg(OP_READY, 8'($urandom_range(AAD_FIRST, RDY_AAD_END - 1)),
						$urandom_range(0, 1));
					default: send_msg(OP_CMD, {GRP_UNCONFIG, SUB_IFC}, 1'b0);
				endcase
			end
			7: begin
				send_msg(OP_CMD, {$urandom_range(0, 1) ? GRP_LISTEN : GRP_TALK,
					5'($urandom)}, 1'b0);
				send_msg($urandom_range(0, 1) ? OP_DATA : OP_READY, 8'($urandom),
					$urandom_range(0, 1));
			end
			default: begin
				repeat ($urandom_range(1, 4))
					send_frame(in_item_t'(30'($urandom)));
			end
		endcase
	endtask

	task automatic test_random_phases();
		int unsigned phase_end;
		for (int ph = 0; ph < 5; ph++) begin
			wait_idle();
			case (ph)
				0: apply_settings(64'h0, 64'h0, 8'h00, 5'd0);
				1: apply_settings({8{8'hFF}}, {8{8'hFF}}, 8'hFF, 5'd31);
				2: apply_settings(64'h0000_0031_3441_5048, 64'h0, 8'($urandom), 5'd30);
				3: apply_settings({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom),
					5'($urandom));
				default: apply_settings({$urandom, 8'h00, 24'($urandom)}, {$urandom, $urandom},
					8'($urandom), 5'($urandom_range(0, 31)));
			endcase
			phase_end = frames_sent + PHASE_FRAMES;
			while (frames_sent < phase_end)
				send_random_sequence();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_auto_address();
		test_listener();
		test_talker();
		test_send_id();
		test_random_phases();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_frames.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ldtl_pkg.sv
rtl/ldtl_front.sv
rtl/ldtl_back.sv
rtl/loop_device_talker_listener_unit.sv
tb/sv/tb_loop_device_talker_listener_unit.sv
